// File: rtl/maze_wall_map_engine_core_assert.svh
// assertion helpers for the wall map engine
`ifndef MAZE_WALL_MAP_ENGINE_CORE_ASSERT_SVH
`define MAZE_WALL_MAP_ENGINE_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define MWME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MWME_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/mwme_pkg.sv
`default_nettype none

package mwme_pkg;

  // coordinate width on the ports
  localparam int unsigned CW = 5;

  // request codes
  localparam logic [2:0] REQ_INIT    = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_SETWALL = 3'd2;
  localparam logic [2:0] REQ_SENSORS = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_ADVANCE = 3'd5;
  localparam logic [2:0] REQ_TURN    = 3'd6;
  localparam logic [2:0] REQ_SETPOS  = 3'd7;

  // direction codes
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_START_ROW     = 3'd0;
  localparam logic [2:0] CFG_START_COL     = 3'd1;
  localparam logic [2:0] CFG_START_HEADING = 3'd2;
  localparam logic [2:0] CFG_GOAL_ROW_MIN  = 3'd3;
  localparam logic [2:0] CFG_GOAL_ROW_MAX  = 3'd4;
  localparam logic [2:0] CFG_GOAL_COL_MIN  = 3'd5;
  localparam logic [2:0] CFG_GOAL_COL_MAX  = 3'd6;

  // register reset values
  localparam logic [3:0] RST_START_ROW     = 4'd15;
  localparam logic [3:0] RST_START_COL     = 4'd0;
  localparam logic [1:0] RST_START_HEADING = 2'd0;
  localparam logic [3:0] RST_GOAL_ROW_MIN  = 4'd7;
  localparam logic [3:0] RST_GOAL_ROW_MAX  = 4'd8;
  localparam logic [3:0] RST_GOAL_COL_MIN  = 4'd7;
  localparam logic [3:0] RST_GOAL_COL_MAX  = 4'd8;

  localparam logic [7:0] WALLS_OUTSIDE = 8'hFF;

  // wall bit on side a of a cell
  function automatic logic [3:0] side_bit(input logic [1:0] a);
    return 4'b0001 << a;
  endfunction

  // wall bit of the neighbor that faces side a
  function automatic logic [3:0] facing_bit(input logic [1:0] a);
    logic [1:0] opp;
    opp = a + 2'd2;
    return 4'b0001 << opp;
  endfunction

  // walls seen by the front, left and right sensors at heading d
  function automatic logic [3:0] sensor_mask(input logic [1:0] d, input logic wf,
                                             input logic wl, input logic wr);
    logic [3:0] m;
    m = '0;
    if (wf) m = m | side_bit(d);
    if (wl) m = m | side_bit(d + 2'd3);
    if (wr) m = m | side_bit(d + 2'd1);
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/maze_wall_map_engine_core.sv
`default_nettype none

// Wall map engine: keeps a GRID_SIZE x GRID_SIZE map of wall masks (N=1, E=2,
// S=4, W=8) and visited bits in one synchronous RAM, plus the robot pose and a
// visited counter. One item is worked at a time; each gives one result that
// describes cell (row, col) and side dir after the request, with the pose.
// Timing is set by the single RAM port pair: query, advance, turn and set
// position read the cell once, as do set wall and sensors with an invalid
// side; any request other than init and clear on a cell outside the grid
// skips the RAM. Set wall and sensors that change the map also write the cell
// and make one pass over the four neighbors, writing a facing wall where one
// is needed, and init and clear sweep the whole RAM at one cell per cycle.
// After reset the same sweep runs before the first item is taken. A new item
// may be accepted while the previous result still waits in the output register.
module maze_wall_map_engine_core #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  // request items
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] req_type_i,
  input  wire logic [mwme_pkg::CW-1:0] row_i,
  input  wire logic [mwme_pkg::CW-1:0] col_i,
  input  wire logic [2:0] dir_i,
  input  wire logic       wall_front_i,
  input  wire logic       wall_left_i,
  input  wire logic       wall_right_i,
  input  wire logic [1:0] turn_amount_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      cell_walls_o,
  output logic            wall_in_dir_o,
  output logic            can_move_o,
  output logic            cell_visited_o,
  output logic            cell_is_goal_o,
  output logic            cell_is_start_o,
  output logic [mwme_pkg::CW-1:0] pose_row_o,
  output logic [mwme_pkg::CW-1:0] pose_col_o,
  output logic [1:0]      pose_heading_o,
  output logic [8:0]      visited_total_o,
  output logic            fully_explored_o
);

  import mwme_pkg::*;

  localparam int unsigned NCELLS = GRID_SIZE * GRID_SIZE;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam logic [CW-1:0] GS_C   = CW'(GRID_SIZE);
  localparam logic [CW-1:0] LAST_C = CW'(GRID_SIZE - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NCELLS - 1);
  localparam logic [8:0]    NCELLS_C  = 9'(NCELLS);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_NRD   = 3'd4;
  localparam logic [2:0] S_NWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // ---------------------------------------------------------------------------
  // grid helpers

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(int'(r) * GRID_SIZE + int'(c));
  endfunction

  // walls of a cell right after init or clear
  function automatic logic [3:0] init_walls(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [3:0] sr, input logic [3:0] sc);
    logic [3:0] w;
    w = '0;
    if (r == '0)     w = w | side_bit(DIR_N);
    if (r == LAST_C) w = w | side_bit(DIR_S);
    if (c == '0)     w = w | side_bit(DIR_W);
    if (c == LAST_C) w = w | side_bit(DIR_E);
    if (r == {1'b0, sr} && c == {1'b0, sc}) w = w | side_bit(DIR_E);
    return w;
  endfunction

  // neighbor on side a of an in-grid cell lies in the grid
  function automatic logic nb_inside(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                     input logic [1:0] a);
    logic res;
    case (a)
      DIR_N:   res = (r != '0);
      DIR_E:   res = (c < LAST_C);
      DIR_S:   res = (r < LAST_C);
      DIR_W:   res = (c != '0);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic [AW-1:0] nb_addr(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [1:0] a);
    logic [CW-1:0] nr;
    logic [CW-1:0] nc;
    nr = r;
    nc = c;
    case (a)
      DIR_N:   nr = r - CW'(1);
      DIR_E:   nc = c + CW'(1);
      DIR_S:   nr = r + CW'(1);
      DIR_W:   nc = c - CW'(1);
      default: nr = r;
    endcase
    return cell_addr(nr, nc);
  endfunction

  // ---------------------------------------------------------------------------
  // registers

  logic [2:0] state_q, state_d;
  logic       rst_sweep_q, rst_sweep_d;
  logic [AW-1:0] sw_addr_q, sw_addr_d;
  logic [CW-1:0] sw_row_q, sw_row_d;
  logic [CW-1:0] sw_col_q, sw_col_d;
  logic [3:0] sw_srow_q, sw_srow_d;
  logic [3:0] sw_scol_q, sw_scol_d;
  logic [1:0] nb_q, nb_d;

  logic [3:0] start_row_q, start_col_q;
  logic [1:0] start_heading_q;
  logic [3:0] goal_row_min_q, goal_row_max_q, goal_col_min_q, goal_col_max_q;

  logic [CW-1:0] pose_row_q, pose_row_d;
  logic [CW-1:0] pose_col_q, pose_col_d;
  logic [1:0]    pose_hdg_q, pose_hdg_d;
  logic [8:0]    cnt_q, cnt_d;

  // latched item
  logic [CW-1:0] row_q, col_q;
  logic [1:0]    dir_q;
  logic          dvalid_q, ok_q, mod_q, sens_q;
  logic [3:0]    mask_q;
  logic [3:0]    cur_walls_q, cur_walls_d;
  logic          cur_vis_q, cur_vis_d;

  logic out_valid_q, out_valid_d;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [4:0]    ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // request decode

  logic       accept;
  logic       in_ok, in_dvalid;
  logic [3:0] in_mask;
  logic       in_mod, in_sens;
  logic       out_fire;
  logic       nb_need;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ok      = (row_i < GS_C) && (col_i < GS_C);
  assign in_dvalid  = !dir_i[2];
  assign in_mod     = in_ok && in_dvalid &&
                      ((req_type_i == REQ_SETWALL) || (req_type_i == REQ_SENSORS));
  assign in_sens    = in_ok && in_dvalid && (req_type_i == REQ_SENSORS);
  assign in_mask    = (req_type_i == REQ_SENSORS) ?
                      sensor_mask(dir_i[1:0], wall_front_i, wall_left_i, wall_right_i) :
                      side_bit(dir_i[1:0]);
  assign out_fire   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign nb_need    = mask_q[nb_q] && nb_inside(row_q, col_q, nb_q);

  // ---------------------------------------------------------------------------
  // sequencer

  always_comb begin
    state_d     = state_q;
    rst_sweep_d = rst_sweep_q;
    sw_addr_d   = sw_addr_q;
    sw_row_d    = sw_row_q;
    sw_col_d    = sw_col_q;
    sw_srow_d   = sw_srow_q;
    sw_scol_d   = sw_scol_q;
    nb_d        = nb_q;
    pose_row_d  = pose_row_q;
    pose_col_d  = pose_col_q;
    pose_hdg_d  = pose_hdg_q;
    cnt_d       = cnt_q;
    cur_walls_d = cur_walls_q;
    cur_vis_d   = cur_vis_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr(row_q, col_q);
    ram_wdata   = {cur_vis_q, cur_walls_q};
    ram_raddr   = cell_addr(row_q, col_q);

    // result handshake
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cur_walls_d = init_walls(row_i, col_i, start_row_q, start_col_q);
          cur_vis_d   = 1'b0;
          // pose update
          case (req_type_i)
            REQ_INIT: begin
              pose_row_d = {1'b0, start_row_q};
              pose_col_d = {1'b0, start_col_q};
              pose_hdg_d = start_heading_q;
            end
            REQ_ADVANCE: begin
              if (in_dvalid) begin
                case (dir_i[1:0])
                  DIR_N:   pose_row_d = pose_row_q - CW'(1);
                  DIR_E:   pose_col_d = pose_col_q + CW'(1);
                  DIR_S:   pose_row_d = pose_row_q + CW'(1);
                  DIR_W:   pose_col_d = pose_col_q - CW'(1);
                  default: pose_row_d = pose_row_q;
                endcase
                pose_hdg_d = dir_i[1:0];
              end
            end
            REQ_TURN: begin
              pose_hdg_d = pose_hdg_q + turn_amount_i;
            end
            REQ_SETPOS: begin
              pose_row_d = in_ok ? row_i : {1'b0, start_row_q};
              pose_col_d = in_ok ? col_i : {1'b0, start_col_q};
              pose_hdg_d = in_dvalid ? dir_i[1:0] : DIR_N;
            end
            default: begin
              pose_hdg_d = pose_hdg_q;
            end
          endcase
          // next step
          if ((req_type_i == REQ_INIT) || (req_type_i == REQ_CLEAR)) begin
            cnt_d     = '0;
            sw_addr_d = '0;
            sw_row_d  = '0;
            sw_col_d  = '0;
            sw_srow_d = start_row_q;
            sw_scol_d = start_col_q;
            state_d   = S_SWEEP;
          end else if (in_ok) begin
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // write the fresh value of one cell per cycle
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_addr_q;
        ram_wdata = {1'b0, init_walls(sw_row_q, sw_col_q, sw_srow_q, sw_scol_q)};
        sw_addr_d = sw_addr_q + AW'(1);
        if (sw_col_q == LAST_C) begin
          sw_col_d = '0;
          sw_row_d = sw_row_q + CW'(1);
        end else begin
          sw_col_d = sw_col_q + CW'(1);
        end
        if (sw_addr_q == LAST_ADDR) begin
          rst_sweep_d = 1'b0;
          state_d     = rst_sweep_q ? S_IDLE : S_DONE;
        end
      end

      S_RD: begin
        state_d = S_MOD;
      end

      // center cell: read data is back, merge, and write when the item changes the map
      S_MOD: begin
        cur_walls_d = ram_rdata[3:0] | (mod_q ? mask_q : 4'b0000);
        cur_vis_d   = ram_rdata[4] | sens_q;
        ram_we      = mod_q;
        ram_wdata   = {cur_vis_d, cur_walls_d};
        if (sens_q && !ram_rdata[4]) begin
          cnt_d = cnt_q + 9'd1;
        end
        nb_d    = DIR_N;
        state_d = mod_q ? S_NRD : S_DONE;
      end

      // neighbor pass: read the neighbor that needs a facing wall
      S_NRD: begin
        ram_raddr = nb_addr(row_q, col_q, nb_q);
        if (nb_need) begin
          state_d = S_NWR;
        end else if (nb_q == DIR_W) begin
          state_d = S_DONE;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end

      S_NWR: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr(row_q, col_q, nb_q);
        ram_wdata = ram_rdata | {1'b0, facing_bit(nb_q)};
        if (nb_q == DIR_W) begin
          state_d = S_DONE;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_NRD;
        end
      end

      S_DONE: begin
        if (out_fire) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      rst_sweep_q <= 1'b1;
      sw_addr_q   <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      sw_srow_q   <= RST_START_ROW;
      sw_scol_q   <= RST_START_COL;
      nb_q        <= DIR_N;
      pose_row_q  <= {1'b0, RST_START_ROW};
      pose_col_q  <= {1'b0, RST_START_COL};
      pose_hdg_q  <= RST_START_HEADING;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rst_sweep_q <= rst_sweep_d;
      sw_addr_q   <= sw_addr_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
      sw_srow_q   <= sw_srow_d;
      sw_scol_q   <= sw_scol_d;
      nb_q        <= nb_d;
      pose_row_q  <= pose_row_d;
      pose_col_q  <= pose_col_d;
      pose_hdg_q  <= pose_hdg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q     <= RST_START_ROW;
      start_col_q     <= RST_START_COL;
      start_heading_q <= RST_START_HEADING;
      goal_row_min_q  <= RST_GOAL_ROW_MIN;
      goal_row_max_q  <= RST_GOAL_ROW_MAX;
      goal_col_min_q  <= RST_GOAL_COL_MIN;
      goal_col_max_q  <= RST_GOAL_COL_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_ROW:     start_row_q     <= cfg_data_i;
        CFG_START_COL:     start_col_q     <= cfg_data_i;
        CFG_START_HEADING: start_heading_q <= cfg_data_i[1:0];
        CFG_GOAL_ROW_MIN:  goal_row_min_q  <= cfg_data_i;
        CFG_GOAL_ROW_MAX:  goal_row_max_q  <= cfg_data_i;
        CFG_GOAL_COL_MIN:  goal_col_min_q  <= cfg_data_i;
        CFG_GOAL_COL_MAX:  goal_col_max_q  <= cfg_data_i;
        default:           start_row_q     <= start_row_q;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_i;
      col_q    <= col_i;
      dir_q    <= dir_i[1:0];
      dvalid_q <= in_dvalid;
      ok_q     <= in_ok;
      mod_q    <= in_mod;
      sens_q   <= in_sens;
      mask_q   <= in_mask;
    end
    cur_walls_q <= cur_walls_d;
    cur_vis_q   <= cur_vis_d;
  end

  // ---------------------------------------------------------------------------
  // map memory: {visited, walls}

  mwme_ram #(
    .WIDTH (5),
    .DEPTH (NCELLS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // result register

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      cell_walls_o    <= ok_q ? {4'b0000, cur_walls_q} : WALLS_OUTSIDE;
      wall_in_dir_o   <= (ok_q && dvalid_q) ? cur_walls_q[dir_q] : 1'b1;
      can_move_o      <= ok_q && dvalid_q && !cur_walls_q[dir_q] &&
                         nb_inside(row_q, col_q, dir_q);
      cell_visited_o  <= ok_q && cur_vis_q;
      cell_is_goal_o  <= (row_q >= {1'b0, goal_row_min_q}) &&
                         (row_q <= {1'b0, goal_row_max_q}) &&
                         (col_q >= {1'b0, goal_col_min_q}) &&
                         (col_q <= {1'b0, goal_col_max_q});
      cell_is_start_o <= (row_q == {1'b0, start_row_q}) &&
                         (col_q == {1'b0, start_col_q});
      pose_row_o      <= pose_row_q;
      pose_col_o      <= pose_col_q;
      pose_heading_o  <= pose_hdg_q;
      visited_total_o <= cnt_q;
      fully_explored_o <= (cnt_q == NCELLS_C);
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // assertions

`include "maze_wall_map_engine_core_assert.svh"

  `MWME_ASSERT(a_accept_leaves_idle, (accept |=> state_q != S_IDLE), "item accepted but sequencer stayed idle")
  `MWME_ASSERT_NEVER(a_no_write_when_idle, (ram_we && state_q == S_IDLE), "map written while idle")
  `MWME_ASSERT_NEVER(a_count_in_range, (cnt_q > NCELLS_C), "visited count beyond grid size")
  `MWME_ASSERT(a_count_step, (1'b1 |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 9'd1 || cnt_q == '0)), "visited count jumped")

endmodule

`default_nettype wire

// File: rtl/mwme_ram.sv
`default_nettype none

module mwme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
